// File: design/stochastic_monotone_bound_rows_unit_assert.svh
// Assertion macros used by the st-monotone bound checker.
`ifndef STOCHASTIC_MONOTONE_BOUND_ROWS_UNIT_ASSERT_SVH
`define STOCHASTIC_MONOTONE_BOUND_ROWS_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SMB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smb assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smb assertion failed");

`endif

// File: design/smb_pkg.sv
// Package: constants and types of the st-monotone bound unit.
`timescale 1ns / 1ps
package smb_pkg;
    localparam int SMB_MAX_STATES  = 1024;
    localparam int SMB_PROB_W      = 31;
    localparam int SMB_VAL_W       = 32;
    localparam int SMB_STATES_W    = 11;
    localparam int SMB_COL_W       = 10;
    localparam int SMB_DEG_W       = 11;
    localparam int SMB_CFG_IDX_W   = 2;
    localparam int SMB_CFG_DATA_W  = 32;
    localparam int SMB_STATES_RST  = 1024;

    typedef enum logic [SMB_CFG_IDX_W-1:0] {
        REG_BOUND_MODE     = 2'd0,
        REG_STATES_IN_USE  = 2'd1,
        REG_ZERO_THRESHOLD = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        MODE_UPPER = 1'b0,
        MODE_LOWER = 1'b1
    } t_bound_mode;
endpackage

// File: design/smb_cfg_if.sv
// Interface: configuration write channel.
`timescale 1ns / 1ps
interface smb_cfg_if import smb_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [SMB_CFG_IDX_W-1:0]  index;
    logic [SMB_CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/smb_in_if.sv
// Interface: matrix entry input channel.
`timescale 1ns / 1ps
interface smb_in_if import smb_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [SMB_PROB_W-1:0] prob;
    logic                  first_row;

    modport source (output valid, output prob, output first_row, input ready);
    modport sink   (input valid, input prob, input first_row, output ready);
endinterface

// File: design/smb_out_if.sv
// Interface: bound entry output channel.
`timescale 1ns / 1ps
interface smb_out_if import smb_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [SMB_COL_W-1:0] column;
    logic [SMB_VAL_W-1:0] bound_prob;
    logic                 significant;
    logic [SMB_DEG_W-1:0] row_degree;
    logic                 row_end;

    modport source (output valid, output column, output bound_prob, output significant,
                    output row_degree, output row_end, input ready);
    modport sink   (input valid, input column, input bound_prob, input significant,
                    input row_degree, input row_end, output ready);
endinterface

// File: design/smb_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module smb_ram import smb_pkg::*; #(
    parameter int WIDTH = SMB_VAL_W,
    parameter int DEPTH = SMB_MAX_STATES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/stochastic_monotone_bound_rows_unit.sv
// Top level: st-monotone bounding matrix, one entry per item.
// Pipeline: input accept loads the read stage (suffix store read), then the output register.
// Throughput: 1 item per cycle unless the output is held off; the suffix store has one
// read and one write port, with forwarding when consecutive items hit the same column.
// Reset: sync active low; control regs reset, data regs and suffix store undefined.
`timescale 1ns / 1ps
module stochastic_monotone_bound_rows_unit import smb_pkg::*; #(
    parameter int MAX_STATES = SMB_MAX_STATES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smb_cfg_if.sink   i_cfg,
    smb_in_if.sink    i_in,
    smb_out_if.source o_res
);
    localparam int AW = $clog2(MAX_STATES);

    function automatic logic [AW-1:0] eff_m1(input logic [SMB_STATES_W-1:0] n);
        logic [31:0] e;
        e = 32'(n);
        if (e == 32'd0) begin
            e = 32'd1;
        end
        if (e > 32'(MAX_STATES)) begin
            e = 32'(MAX_STATES);
        end
        return AW'(e - 32'd1);
    endfunction

    localparam logic [AW-1:0] RST_COL = eff_m1(SMB_STATES_W'(SMB_STATES_RST));

    // configuration
    t_bound_mode             r_mode;
    logic [SMB_STATES_W-1:0] r_states;
    logic [SMB_PROB_W-1:0]   r_thresh;

    // row state
    logic [AW-1:0]          r_col;
    logic [SMB_VAL_W-1:0]   r_acc;
    logic [SMB_VAL_W-1:0]   r_last;
    logic [SMB_DEG_W-1:0]   r_deg;

    // read stage
    logic                   r_s1_valid;
    logic [AW-1:0]          r_s1_col;
    logic [SMB_PROB_W-1:0]  r_s1_prob;
    logic                   r_s1_first;
    logic                   r_s1_fwd;
    logic [SMB_VAL_W-1:0]   r_s1_fwd_data;

    // output register
    logic                   r_o_valid;
    logic [SMB_COL_W-1:0]   r_o_col;
    logic [SMB_VAL_W-1:0]   r_o_val;
    logic                   r_o_sig;
    logic [SMB_DEG_W-1:0]   r_o_deg;
    logic                   r_o_end;

    logic                   cfg_wr;
    logic                   s1_adv;
    logic                   in_rdy;
    logic                   accept;
    logic [SMB_VAL_W-1:0]   ram_rdata;
    logic [SMB_VAL_W-1:0]   prev;
    logic [SMB_VAL_W:0]     sum;
    logic [SMB_VAL_W-1:0]   acc;
    logic [SMB_VAL_W-1:0]   news;
    logic [SMB_VAL_W-1:0]   value;
    logic                   sig;
    logic [SMB_DEG_W-1:0]   deg_new;
    logic                   s1_end;
    logic [31:0]            col32;

    assign cfg_wr = i_cfg.valid && i_cfg.ready;
    assign s1_adv = r_s1_valid && (!r_o_valid || o_res.ready);
    assign in_rdy = i_rst_n && (!r_s1_valid || s1_adv);
    assign accept = i_in.valid && in_rdy;

    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = in_rdy;

    smb_ram #(
        .WIDTH (SMB_VAL_W),
        .DEPTH (MAX_STATES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (news),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        prev  = r_s1_fwd ? r_s1_fwd_data : ram_rdata;
        sum   = {1'b0, r_acc} + (SMB_VAL_W + 1)'(r_s1_prob);
        acc   = sum[SMB_VAL_W] ? '1 : sum[SMB_VAL_W-1:0];
        if (r_s1_first) begin
            news  = acc;
            value = SMB_VAL_W'(r_s1_prob);
        end else begin
            if (r_mode == MODE_UPPER) begin
                news = (acc > prev) ? acc : prev;
            end else begin
                news = (acc > prev) ? prev : acc;
            end
            value = (news >= r_last) ? news - r_last : '0;
        end
        sig     = value > SMB_VAL_W'(r_thresh);
        deg_new = (sig && r_deg != '1) ? r_deg + 1'b1 : r_deg;
        s1_end  = r_s1_col == '0;
        col32   = 32'(r_s1_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_UPPER;
            r_states   <= SMB_STATES_W'(SMB_STATES_RST);
            r_thresh   <= '0;
            r_col      <= RST_COL;
            r_acc      <= '0;
            r_last     <= '0;
            r_deg      <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= (r_col == '0) ? eff_m1(r_states) : r_col - 1'b1;
            end
            if (s1_adv) begin
                if (s1_end) begin
                    r_acc  <= '0;
                    r_last <= '0;
                    r_deg  <= '0;
                end else begin
                    r_acc  <= acc;
                    r_last <= news;
                    r_deg  <= deg_new;
                end
            end
            if (cfg_wr) begin
                unique case (i_cfg.index)
                    REG_BOUND_MODE: begin
                        r_mode <= t_bound_mode'(i_cfg.data[0]);
                    end
                    REG_STATES_IN_USE: begin
                        r_states <= i_cfg.data[SMB_STATES_W-1:0];
                        r_col    <= eff_m1(i_cfg.data[SMB_STATES_W-1:0]);
                        r_acc    <= '0;
                        r_last   <= '0;
                        r_deg    <= '0;
                    end
                    REG_ZERO_THRESHOLD: begin
                        r_thresh <= i_cfg.data[SMB_PROB_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col      <= r_col;
            r_s1_prob     <= i_in.prob;
            r_s1_first    <= i_in.first_row;
            r_s1_fwd      <= s1_adv && (r_s1_col == r_col);
            r_s1_fwd_data <= news;
        end
        if (s1_adv) begin
            r_o_col <= col32[SMB_COL_W-1:0];
            r_o_val <= value;
            r_o_sig <= sig;
            r_o_deg <= deg_new;
            r_o_end <= s1_end;
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.column      = r_o_col;
    assign o_res.bound_prob  = r_o_val;
    assign o_res.significant = r_o_sig;
    assign o_res.row_degree  = r_o_deg;
    assign o_res.row_end     = r_o_end;
endmodule

// File: design/smb_checker.sv
// Checker: port-level assertions for the st-monotone bound unit, with bind.
`timescale 1ns / 1ps
`include "stochastic_monotone_bound_rows_unit_assert.svh"
module smb_checker import smb_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [SMB_COL_W-1:0] i_out_column,
    input logic [SMB_VAL_W-1:0] i_out_bound_prob,
    input logic                 i_out_significant,
    input logic [SMB_DEG_W-1:0] i_out_row_degree,
    input logic                 i_out_row_end
);
    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    `SMB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_bound_prob) && $stable(i_out_column))
    `SMB_ASSERT_NOW(a_end_col0, i_clk, i_rst_n, i_out_valid && i_out_row_end, i_out_column == '0)
    `SMB_ASSERT_NOW(a_sig_deg, i_clk, i_rst_n, i_out_valid && i_out_significant, i_out_row_degree != '0)
    `SMB_ASSERT_NOW(a_out_cause, i_clk, i_rst_n, $rose(i_out_valid), $past(in_acc, 2))
endmodule

bind stochastic_monotone_bound_rows_unit smb_checker u_smb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_out_column      (o_res.column),
    .i_out_bound_prob  (o_res.bound_prob),
    .i_out_significant (o_res.significant),
    .i_out_row_degree  (o_res.row_degree),
    .i_out_row_end     (o_res.row_end)
);

// File: test/stochastic_monotone_bound_rows_unit_tb.sv
// Testbench: st-monotone bound unit driven with matrix rows, checked against a local predictor.
`timescale 1ns / 1ps
module stochastic_monotone_bound_rows_unit_tb;
    import smb_pkg::*;

    localparam logic [SMB_CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [SMB_PROB_W-1:0]    PROB_ONE   = 31'h4000_0000;
    localparam int ITEM_TARGET   = 1970;
    localparam int HOLD_CYCLES   = 300;
    localparam int LATENCY_PAD   = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 100;

    typedef struct packed {
        logic [SMB_PROB_W-1:0] prob;
        logic                  first_row;
    } t_matrix_entry;

    typedef struct packed {
        logic [SMB_COL_W-1:0] column;
        logic [SMB_VAL_W-1:0] bound_prob;
        logic                 significant;
        logic [SMB_DEG_W-1:0] row_degree;
        logic                 row_end;
    } t_bound_entry;

    typedef enum int {ROW_STOCHASTIC, ROW_RAW, ROW_PARTIAL} t_row_kind;

    logic i_clk;
    logic i_rst_n;

    smb_cfg_if cfg_bus ();
    smb_in_if  in_bus ();
    smb_out_if res_bus ();

    stochastic_monotone_bound_rows_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_res   (res_bus)
    );

    t_matrix_entry pending_entries[$];
    t_bound_entry  expected_bounds[$];
    t_matrix_entry offered;
    t_bound_entry  want;

    // predictor state
    t_bound_mode              mdl_mode;
    logic [SMB_STATES_W-1:0]  mdl_states;
    logic [SMB_PROB_W-1:0]    mdl_thr;
    logic [SMB_VAL_W-1:0]     mdl_suffix [SMB_MAX_STATES];
    logic [SMB_VAL_W-1:0]     mdl_acc;
    logic [SMB_VAL_W-1:0]     mdl_last;
    logic [SMB_DEG_W-1:0]     mdl_deg;
    int                       mdl_col;

    // stimulus-side shadow of the column walk and of which store entries hold data
    int                       gen_n;
    int                       gen_col;
    bit [SMB_MAX_STATES-1:0]  gen_written;

    int items_queued;
    int mismatch_count;
    int idle_pct;
    int hold_reqs;
    int hold_done;
    int hold_left;
    int stall_cycles;
    int phase_no;
    int row_cnt;
    int row_no;
    int size_sel;
    bit must_resize;
    logic [31:0] reg_val;

    function automatic int eff_states(input logic [SMB_STATES_W-1:0] n);
        if (n == 0) return 1;
        if (n > SMB_MAX_STATES) return SMB_MAX_STATES;
        return int'(n);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) $display("error: %s", what);
    endtask

    task automatic restart_row();
        mdl_acc  = '0;
        mdl_last = '0;
        mdl_deg  = '0;
        mdl_col  = eff_states(mdl_states) - 1;
    endtask

    task automatic predict_bound(input logic [SMB_PROB_W-1:0] prob, input logic first);
        logic [SMB_VAL_W:0]   sum;
        logic [SMB_VAL_W-1:0] acc;
        logic [SMB_VAL_W-1:0] prev;
        logic [SMB_VAL_W-1:0] news;
        logic [SMB_VAL_W-1:0] value;
        logic                 sig;
        int                   col;
        col = mdl_col;
        sum = {1'b0, mdl_acc} + (SMB_VAL_W+1)'(prob);
        acc = sum[SMB_VAL_W] ? '1 : sum[SMB_VAL_W-1:0];
        mdl_acc = acc;
        if (first) begin
            news  = acc;
            value = {1'b0, prob};
        end else begin
            prev = mdl_suffix[col];
            if (mdl_mode == MODE_UPPER) news = (acc > prev) ? acc : prev;
            else news = (acc > prev) ? prev : acc;
            value = (news >= mdl_last) ? news - mdl_last : '0;
        end
        mdl_suffix[col] = news;
        mdl_last = news;
        sig = value > {1'b0, mdl_thr};
        if (sig && mdl_deg != '1) mdl_deg++;
        expected_bounds.push_back('{column: SMB_COL_W'(col), bound_prob: value,
                                    significant: sig, row_degree: mdl_deg,
                                    row_end: (col == 0)});
        if (col == 0) restart_row();
        else mdl_col = col - 1;
    endtask

    task automatic queue_entry(input logic [SMB_PROB_W-1:0] prob, input logic first);
        // never let the block read a store entry that holds nothing yet
        pending_entries.push_back('{prob: prob, first_row: first || !gen_written[gen_col]});
        gen_written[gen_col] = 1'b1;
        gen_col = (gen_col == 0) ? gen_n - 1 : gen_col - 1;
        items_queued++;
    endtask

    task automatic queue_row(input t_row_kind kind, input logic first);
        logic [SMB_PROB_W-1:0] left;
        logic [SMB_PROB_W-1:0] p;
        int                    cnt;
        left = PROB_ONE;
        cnt  = (kind == ROW_PARTIAL && gen_col > 0) ? $urandom_range(1, gen_col) : gen_col + 1;
        repeat (cnt) begin
            if (kind == ROW_STOCHASTIC) begin
                if (gen_col == 0) p = left;
                else if ($urandom_range(0, 3) == 0) p = '0;
                else p = SMB_PROB_W'($urandom_range(0, left));
                left = left - p;
            end else begin
                case ($urandom_range(0, 3))
                    0: p = PROB_ONE;
                    1: p = '0;
                    default: p = SMB_PROB_W'($urandom_range(0, PROB_ONE));
                endcase
            end
            queue_entry(p, first || ($urandom_range(0, 19) == 0));
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_entries.size() != 0 || in_bus.valid || expected_bounds.size() != 0);
        repeat (LATENCY_PAD) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [SMB_CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_BOUND_MODE:     mdl_mode = t_bound_mode'(val[0]);
            REG_STATES_IN_USE: begin
                mdl_states = val[SMB_STATES_W-1:0];
                restart_row();
                gen_n   = eff_states(mdl_states);
                gen_col = gen_n - 1;
            end
            REG_ZERO_THRESHOLD: mdl_thr = val[SMB_PROB_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) predict_bound(offered.prob, offered.first_row);
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_entries.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    offered = pending_entries.pop_front();
                    in_bus.valid     <= 1'b1;
                    in_bus.prob      <= offered.prob;
                    in_bus.first_row <= offered.first_row;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_bounds.size() == 0) begin
                    report_mismatch($sformatf("item with nothing expected, column %0d",
                                              res_bus.column));
                end else begin
                    want = expected_bounds.pop_front();
                    if (res_bus.column !== want.column || res_bus.bound_prob !== want.bound_prob
                        || res_bus.significant !== want.significant
                        || res_bus.row_degree !== want.row_degree
                        || res_bus.row_end !== want.row_end)
                        report_mismatch($sformatf(
                            "col %0d/%0d prob %h/%h sig %b/%b deg %0d/%0d end %b/%b (got/exp)",
                            res_bus.column, want.column, res_bus.bound_prob, want.bound_prob,
                            res_bus.significant, want.significant, res_bus.row_degree,
                            want.row_degree, res_bus.row_end, want.row_end));
                end
            end
            if (hold_left != 0) begin
                res_bus.ready <= 1'b0;
                hold_left     <= hold_left - 1;
            end else if (hold_reqs != hold_done) begin
                res_bus.ready <= 1'b0;
                hold_done     <= hold_done + 1;
                hold_left     <= HOLD_CYCLES;
            end else begin
                res_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = REG_BOUND_MODE;
        cfg_bus.data     = '0;
        in_bus.valid     = 1'b0;
        in_bus.prob      = '0;
        in_bus.first_row = 1'b0;
        res_bus.ready    = 1'b0;
        i_rst_n          = 1'b0;
        stall_cycles     = 0;
        mismatch_count   = 0;
        items_queued     = 0;
        idle_pct         = 20;
        hold_reqs        = 0;
        phase_no         = 0;
        must_resize      = 1'b0;
        mdl_mode         = MODE_UPPER;
        mdl_states       = SMB_STATES_W'(SMB_STATES_RST);
        mdl_thr          = '0;
        foreach (mdl_suffix[i]) mdl_suffix[i] = '0;
        restart_row();
        gen_n       = eff_states(mdl_states);
        gen_col     = gen_n - 1;
        gen_written = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, then a row cut short by a size write
        queue_entry(PROB_ONE, 1'b1);
        queue_entry('0, 1'b1);
        queue_entry(SMB_PROB_W'($urandom_range(0, PROB_ONE)), 1'b1);
        wait_idle();
        write_reg(REG_STATES_IN_USE, 32'd4);
        write_reg(REG_ZERO_THRESHOLD, 32'd0);
        repeat (4) queue_entry(PROB_ONE, 1'b1);   // accumulator saturates
        repeat (4) queue_entry('0, 1'b0);
        wait_idle();
        write_reg(REG_BOUND_MODE, 32'hFFFF_FFFF);
        write_reg(REG_ZERO_THRESHOLD, 32'hFFFF_FFFF);
        queue_entry(PROB_ONE, 1'b0);
        queue_entry('0, 1'b0);
        queue_entry(PROB_ONE >> 1, 1'b0);
        queue_entry(PROB_ONE >> 2, 1'b0);
        wait_idle();
        // stale store after size changes, difference clamps at zero
        write_reg(REG_ZERO_THRESHOLD, 32'(PROB_ONE));
        write_reg(REG_BOUND_MODE, 32'd0);
        write_reg(REG_STATES_IN_USE, 32'd2);
        queue_entry(PROB_ONE, 1'b1);
        queue_entry('0, 1'b1);
        wait_idle();
        write_reg(REG_STATES_IN_USE, 32'hFFFF_F800);   // size 0 acts as 1
        queue_entry(PROB_ONE, 1'b0);
        queue_entry('0, 1'b1);
        wait_idle();
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_STATES_IN_USE, 32'd2);
        write_reg(REG_BOUND_MODE, 32'd1);
        queue_entry(PROB_ONE, 1'b0);
        queue_entry(PROB_ONE, 1'b0);

        while (items_queued < ITEM_TARGET) begin
            phase_no++;
            wait_idle();
            if (phase_no == 9) begin
                // full-size row: receiver holds off, then streaming with no gaps
                write_reg(REG_STATES_IN_USE, 32'({$urandom, 11'h7FF}));
                write_reg(REG_ZERO_THRESHOLD, 32'd0);
                repeat (SMB_MAX_STATES)
                    queue_entry(SMB_PROB_W'($urandom_range(1, PROB_ONE)), 1'b1);
                idle_pct = 0;
                hold_reqs++;
                wait_idle();
                idle_pct = 20;
                must_resize = 1'b1;
            end else if (phase_no == 14) begin
                write_reg(REG_STATES_IN_USE, 32'(SMB_MAX_STATES / 2));
                queue_row(ROW_RAW, 1'b0);
                must_resize = 1'b1;
            end else begin
                if ($urandom_range(0, 1) == 1) write_reg(REG_BOUND_MODE, $urandom);
                if ($urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 4))
                        0: reg_val = 32'd0;
                        1: reg_val = 32'(PROB_ONE);
                        2: reg_val = $urandom_range(0, PROB_ONE);
                        3: reg_val = $urandom_range(0, 32'h0400_0000);
                        default: reg_val = $urandom;
                    endcase
                    write_reg(REG_ZERO_THRESHOLD, reg_val);
                end
                if (phase_no % 17 == 3) write_reg(REG_UNUSED, $urandom);
                if (must_resize || $urandom_range(0, 2) != 0) begin
                    size_sel = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48)
                                                           : $urandom_range(1, 8);
                    if (phase_no == 5) size_sel = 0;
                    reg_val = 32'({$urandom, 11'h000}) | 32'(size_sel);
                    write_reg(REG_STATES_IN_USE, reg_val);
                    must_resize = 1'b0;
                end
                row_cnt = $urandom_range(1, 6);
                for (row_no = 0; row_no < row_cnt; row_no++) begin
                    case ($urandom_range(0, 9))
                        7, 8:    queue_row(ROW_RAW, 1'b0);
                        9:       queue_row(ROW_PARTIAL, 1'b0);
                        default: queue_row(ROW_STOCHASTIC,
                                           row_no == 0 && $urandom_range(0, 2) == 0);
                    endcase
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: stochastic_monotone_bound_rows_unit.f
+incdir+design
design/smb_pkg.sv
design/smb_cfg_if.sv
design/smb_in_if.sv
design/smb_out_if.sv
design/smb_ram.sv
design/stochastic_monotone_bound_rows_unit.sv
design/smb_checker.sv
test/stochastic_monotone_bound_rows_unit_tb.sv
